// File: design/apid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apid_pkg
// shared constants and register map of the averaged pid controller
// ----------------------------------------------------------------------------
package apid_pkg;

  // samples per averaging group
  localparam int Samples = 8;

  localparam int SampleW = 12;
  localparam int SumW    = $clog2(Samples * (1 << SampleW));
  localparam int CntW    = (Samples > 1) ? $clog2(Samples) : 1;

  localparam int ErrW    = SampleW + 1;
  localparam int DiffW   = ErrW + 1;
  localparam int GainW   = 16;
  localparam int IntW    = 32;
  localparam int DutyW   = 16;

  // products and sum
  localparam int PTermW  = GainW + ErrW;
  localparam int ITermW  = GainW + IntW;
  localparam int DTermW  = GainW + DiffW;
  localparam int TotalW  = ITermW + 2;
  localparam int QW      = TotalW - 8;

  localparam logic signed [ErrW-1:0] ErrOne = ErrW'(1);

  // apb register map, word index = paddr[AddrW-1:2]
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int IdxW    = AddrW - 2;

  localparam logic [IdxW-1:0] RegSetpoint = 3'd0;
  localparam logic [IdxW-1:0] RegKp       = 3'd1;
  localparam logic [IdxW-1:0] RegKiDt     = 3'd2;
  localparam logic [IdxW-1:0] RegKdOverDt = 3'd3;
  localparam logic [IdxW-1:0] RegPwmMin   = 3'd4;
  localparam logic [IdxW-1:0] RegPwmMax   = 3'd5;

  localparam logic [SampleW-1:0] SetpointRst = 12'd2048;
  localparam logic [GainW-1:0]   KpRst       = 16'd256;
  localparam logic [DutyW-1:0]   PwmMaxRst   = 16'hffff;

endpackage

// File: design/averaged_pid_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// averaged_pid_controller_core
// moving-average front end feeding a pid update with clamped duty output
// ----------------------------------------------------------------------------
// usage
//   in channel: one 12-bit sensor sample per transaction (in_valid/in_stall)
//   out channel: one duty/average transaction for every group of samples
//   (out_valid/out_stall); the other samples of a group give no result
//   apb port: setpoint, kp, ki_dt, kd_over_dt, pwm_min, pwm_max at byte
//   addresses 0,4,..,20; write only while the block is idle; pready is tied high
// timing
//   a sample is captured in an input register, then combinational logic
//   (accumulate, average, integral, three multipliers, clamp) updates the
//   state and loads the result register, which drives out_valid; throughput
//   one sample per cycle unless a group-closing sample waits on out_stall,
//   set by the update of the integral and previous error between the input
//   and result registers
// reset and backpressure
//   rst_n (synchronous, active low) clears sum, count, integral, previous
//   error and restores the register defaults
//   while out_stall holds a result, samples that close no group still pass;
//   a group-closing sample waits in the input register and in_stall rises
// ----------------------------------------------------------------------------
module averaged_pid_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // sample input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [apid_pkg::SampleW-1:0]        in_sample,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [apid_pkg::DutyW-1:0]          out_duty,
  output logic [apid_pkg::SampleW-1:0]        out_average,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [apid_pkg::AddrW-1:0]          paddr,
  input  logic [apid_pkg::DataW-1:0]          pwdata,
  output logic [apid_pkg::DataW-1:0]          prdata,
  output logic                                pready
);

  // configuration registers
  logic [apid_pkg::SampleW-1:0]      setpoint_r;
  logic signed [apid_pkg::GainW-1:0] kp_r;
  logic signed [apid_pkg::GainW-1:0] ki_dt_r;
  logic signed [apid_pkg::GainW-1:0] kd_over_dt_r;
  logic [apid_pkg::DutyW-1:0]        pwm_min_r;
  logic [apid_pkg::DutyW-1:0]        pwm_max_r;

  // controller state
  logic [apid_pkg::SumW-1:0]         sample_sum_r,  sample_sum_nxt;
  logic [apid_pkg::CntW-1:0]         sample_count_r, sample_count_nxt;
  logic signed [apid_pkg::IntW-1:0]  integral_r,    integral_nxt;
  logic signed [apid_pkg::ErrW-1:0]  prev_error_r;

  // input register
  logic                              s1_valid_r;
  logic [apid_pkg::SampleW-1:0]      s1_sample_r;

  // result register
  logic                              out_valid_r;
  logic [apid_pkg::DutyW-1:0]        out_duty_r,    out_duty_nxt;
  logic [apid_pkg::SampleW-1:0]      out_average_r, out_average_nxt;

  // datapath
  logic                              s1_last;
  logic                              s1_fire;
  logic                              out_free;
  logic                              in_accept;
  logic                              cfg_write;
  logic [apid_pkg::IdxW-1:0]         cfg_idx;
  logic [apid_pkg::SumW-1:0]         sum_add;
  logic signed [apid_pkg::ErrW-1:0]  error;
  logic signed [apid_pkg::IntW:0]    int_sum;
  logic signed [apid_pkg::DiffW-1:0] diff;
  logic signed [apid_pkg::PTermW-1:0] p_term;
  logic signed [apid_pkg::ITermW-1:0] i_term;
  logic signed [apid_pkg::DTermW-1:0] d_term;
  logic signed [apid_pkg::TotalW-1:0] total;
  logic signed [apid_pkg::QW-1:0]    q;
  logic signed [apid_pkg::QW-1:0]    lo;
  logic signed [apid_pkg::QW-1:0]    hi;

  // handshake control
  assign s1_last   = (sample_count_r == apid_pkg::CntW'(apid_pkg::Samples - 1));
  assign out_free  = !out_valid_r || !out_stall;
  // a sample that closes no group never needs the result register
  assign s1_fire   = s1_valid_r && (!s1_last || out_free);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = paddr[apid_pkg::AddrW-1:2];
  assign pready    = 1'b1;

  // running sum and group average
  always_comb begin
    sum_add          = sample_sum_r + apid_pkg::SumW'(s1_sample_r);
    out_average_nxt  = apid_pkg::SampleW'(sum_add / apid_pkg::Samples);
    sample_sum_nxt   = s1_last ? '0 : sum_add;
    sample_count_nxt = s1_last ? '0 : sample_count_r + apid_pkg::CntW'(1);
  end

  // error and saturating integral
  always_comb begin
    error   = $signed({1'b0, setpoint_r}) - $signed({1'b0, out_average_nxt});
    int_sum = (apid_pkg::IntW + 1)'(integral_r) + (apid_pkg::IntW + 1)'(error);
    if (int_sum[apid_pkg::IntW] != int_sum[apid_pkg::IntW-1]) begin
      integral_nxt = int_sum[apid_pkg::IntW] ?
                     {1'b1, {(apid_pkg::IntW-1){1'b0}}} :
                     {1'b0, {(apid_pkg::IntW-1){1'b1}}};
    end else begin
      integral_nxt = int_sum[apid_pkg::IntW-1:0];
    end
  end

  // pid terms, floor shift and clamp
  always_comb begin
    diff   = apid_pkg::DiffW'(error) - apid_pkg::DiffW'(prev_error_r);
    p_term = apid_pkg::PTermW'(kp_r) * apid_pkg::PTermW'(error);
    i_term = apid_pkg::ITermW'(ki_dt_r) * apid_pkg::ITermW'(integral_nxt);
    // derivative suppressed for an error of exactly one
    if (error == apid_pkg::ErrOne) begin
      d_term = '0;
    end else begin
      d_term = apid_pkg::DTermW'(kd_over_dt_r) * apid_pkg::DTermW'(diff);
    end
    total = apid_pkg::TotalW'(p_term) + apid_pkg::TotalW'(i_term)
          + apid_pkg::TotalW'(d_term);
    // arithmetic shift drop of 8 bits rounds toward minus infinity
    q  = $signed(total[apid_pkg::TotalW-1:8]);
    lo = $signed({{(apid_pkg::QW - apid_pkg::DutyW){1'b0}}, pwm_min_r});
    hi = $signed({{(apid_pkg::QW - apid_pkg::DutyW){1'b0}}, pwm_max_r});
    // min check wins when the limits cross
    priority if (q < lo) begin
      out_duty_nxt = pwm_min_r;
    end else if (q > hi) begin
      out_duty_nxt = pwm_max_r;
    end else begin
      out_duty_nxt = q[apid_pkg::DutyW-1:0];
    end
  end

  // register read back
  always_comb begin
    unique case (cfg_idx)
      apid_pkg::RegSetpoint: prdata = apid_pkg::DataW'(setpoint_r);
      apid_pkg::RegKp:       prdata = apid_pkg::DataW'($unsigned(kp_r));
      apid_pkg::RegKiDt:     prdata = apid_pkg::DataW'($unsigned(ki_dt_r));
      apid_pkg::RegKdOverDt: prdata = apid_pkg::DataW'($unsigned(kd_over_dt_r));
      apid_pkg::RegPwmMin:   prdata = apid_pkg::DataW'(pwm_min_r);
      apid_pkg::RegPwmMax:   prdata = apid_pkg::DataW'(pwm_max_r);
      default:               prdata = '0;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= apid_pkg::SetpointRst;
      kp_r         <= apid_pkg::KpRst;
      ki_dt_r      <= '0;
      kd_over_dt_r <= '0;
      pwm_min_r    <= '0;
      pwm_max_r    <= apid_pkg::PwmMaxRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        apid_pkg::RegSetpoint: setpoint_r   <= pwdata[apid_pkg::SampleW-1:0];
        apid_pkg::RegKp:       kp_r         <= pwdata[apid_pkg::GainW-1:0];
        apid_pkg::RegKiDt:     ki_dt_r      <= pwdata[apid_pkg::GainW-1:0];
        apid_pkg::RegKdOverDt: kd_over_dt_r <= pwdata[apid_pkg::GainW-1:0];
        apid_pkg::RegPwmMin:   pwm_min_r    <= pwdata[apid_pkg::DutyW-1:0];
        apid_pkg::RegPwmMax:   pwm_max_r    <= pwdata[apid_pkg::DutyW-1:0];
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      sample_sum_r   <= '0;
      sample_count_r <= '0;
      integral_r     <= '0;
      prev_error_r   <= '0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        sample_sum_r   <= sample_sum_nxt;
        sample_count_r <= sample_count_nxt;
        if (s1_last) begin
          integral_r   <= integral_nxt;
          prev_error_r <= error;
        end
      end
      if (s1_fire && s1_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample_r <= in_sample;
    end
    if (s1_fire && s1_last) begin
      out_duty_r    <= out_duty_nxt;
      out_average_r <= out_average_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty    = out_duty_r;
  assign out_average = out_average_r;

  // checks

  // the group counter never passes the last slot
  assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r <= apid_pkg::CntW'(apid_pkg::Samples - 1))
    else $error("sample count out of range");

  // input only backs up when the captured sample is blocked
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last && out_valid_r && out_stall))
    else $error("input stalled without a blocked group end");

  // a closing sample always yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last) |=> out_valid_r)
    else $error("group end lost its result");

  // with ordered limits the duty stays in range
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (pwm_min_r <= pwm_max_r)) |->
      (out_duty_r >= pwm_min_r && out_duty_r <= pwm_max_r))
    else $error("duty outside pwm limits");

endmodule

// File: sim/tb_averaged_pid_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_averaged_pid_controller_core
// self-checking bench for the averaged pid controller core
// ----------------------------------------------------------------------------
// a directed table runs first (register extremes, unmapped writes, error of
// one, crossed duty limits), then randomized phases follow: each phase
// reprograms every register over apb and streams sample groups shaped to hit
// the interesting error values. a transaction-level model of the group average,
// saturating integral and clamped pid sum predicts every duty/average
// transaction, which is compared field by field in arrival order. both
// channels idle and stall at random, with occasional full-rate stretches.
// ----------------------------------------------------------------------------
module tb_averaged_pid_controller_core;

  localparam int RandItems   = 850;
  localparam int QuietLimit  = 2000;  // cycles with no transaction at all
  localparam int SettleTicks = 4;     // margin over the input-to-result latency

  // word indexes outside the register map, writes there must be dropped
  localparam logic [apid_pkg::IdxW-1:0] RegUnmappedA = 3'd6;
  localparam logic [apid_pkg::IdxW-1:0] RegUnmappedB = 3'd7;

  localparam longint IntegMax = 64'sd2147483647;
  localparam longint IntegMin = -64'sd2147483648;

  typedef struct packed {
    logic [apid_pkg::DutyW-1:0]   duty;
    logic [apid_pkg::SampleW-1:0] average;
  } pid_result_t;

  typedef enum logic {StepSample, StepWrite} step_kind_t;

  typedef struct packed {
    step_kind_t                 kind;
    logic [apid_pkg::IdxW-1:0]  idx;
    logic [apid_pkg::DataW-1:0] data;   // register value, or the sample in the low bits
    logic                       typed;  // result typed in below instead of predicted
    pid_result_t                res;
  } dir_row_t;

  // directed stimulus, walked in order
  localparam dir_row_t DirTable [33] = '{
    // kd with junk above bit 15, then writes to holes in the map
    '{StepWrite,  apid_pkg::RegKdOverDt, 32'hFFFF_8000, 1'b0, '0},
    '{StepWrite,  RegUnmappedA,          32'h1234_5678, 1'b0, '0},
    '{StepWrite,  RegUnmappedB,          32'hFFFF_FFFF, 1'b0, '0},
    // sample extremes averaging to 2047: error of one kills the large kd term
    '{StepSample, '0, 32'h000, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'h000, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'h000, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'h000, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b1, '{16'd1, 12'd2047}},
    // full-scale samples, derivative drives the sum far above the top limit
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b1, '{16'd65535, 12'd4095}},
    // gain extremes and crossed duty limits
    '{StepWrite,  apid_pkg::RegSetpoint, 32'hFFFF_FFFF, 1'b0, '0},
    '{StepWrite,  apid_pkg::RegKp,       32'h0000_7FFF, 1'b0, '0},
    '{StepWrite,  apid_pkg::RegKiDt,     32'h5A5A_8000, 1'b0, '0},
    '{StepWrite,  apid_pkg::RegKdOverDt, 32'h0000_0000, 1'b0, '0},
    '{StepWrite,  apid_pkg::RegPwmMin,   32'h0000_8000, 1'b0, '0},
    '{StepWrite,  apid_pkg::RegPwmMax,   32'hFFFF_0100, 1'b0, '0},
    '{StepSample, '0, 32'h001, 1'b0, '0},
    '{StepSample, '0, 32'h800, 1'b0, '0},
    '{StepSample, '0, 32'hFFE, 1'b0, '0},
    '{StepSample, '0, 32'h555, 1'b0, '0},
    '{StepSample, '0, 32'hAAA, 1'b0, '0},
    '{StepSample, '0, 32'h7FF, 1'b0, '0},
    '{StepSample, '0, 32'h000, 1'b0, '0},
    '{StepSample, '0, 32'hFFF, 1'b0, '0}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic [apid_pkg::SampleW-1:0] in_sample;
  logic                         out_valid;
  logic                         out_stall;
  logic [apid_pkg::DutyW-1:0]   out_duty;
  logic [apid_pkg::SampleW-1:0] out_average;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [apid_pkg::AddrW-1:0]   paddr;
  logic [apid_pkg::DataW-1:0]   pwdata;
  logic [apid_pkg::DataW-1:0]   prdata;
  logic                         pready;

  // register copies
  logic [apid_pkg::SampleW-1:0]      m_setpoint;
  logic signed [apid_pkg::GainW-1:0] m_kp;
  logic signed [apid_pkg::GainW-1:0] m_ki;
  logic signed [apid_pkg::GainW-1:0] m_kd;
  logic [apid_pkg::DutyW-1:0]        m_pwm_min;
  logic [apid_pkg::DutyW-1:0]        m_pwm_max;

  // controller state copies
  int unsigned grp_sum;
  int          grp_count;
  longint      integ_acc;
  longint      last_err;

  pid_result_t pending_results[$];
  int          fail_count;
  int          quiet_cycles;
  bit          in_burst;
  bit          out_burst;

  averaged_pid_controller_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_sample   (in_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_duty    (out_duty),
    .out_average (out_average),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accumulate one sample; on a group close, run the pid update
  function automatic bit predict_pid(input logic [apid_pkg::SampleW-1:0] s,
                                     output pid_result_t res);
    longint avg, err, d_term, total, q;
    res = '0;
    grp_sum += s;
    grp_count++;
    if (grp_count < apid_pkg::Samples) return 1'b0;
    avg = longint'(grp_sum / apid_pkg::Samples);
    grp_sum = 0;
    grp_count = 0;
    err = longint'(m_setpoint) - avg;
    integ_acc += err;
    if (integ_acc > IntegMax) integ_acc = IntegMax;
    else if (integ_acc < IntegMin) integ_acc = IntegMin;
    // an error of exactly one suppresses the derivative term
    if (err == 1) d_term = 0;
    else d_term = longint'(m_kd) * (err - last_err);
    last_err = err;
    total = longint'(m_kp) * err + longint'(m_ki) * integ_acc + d_term;
    q = total >>> 8;  // arithmetic shift floors toward minus infinity
    // low limit wins when the limits are crossed
    if (q < longint'(m_pwm_min)) q = longint'(m_pwm_min);
    else if (q > longint'(m_pwm_max)) q = longint'(m_pwm_max);
    res.duty    = q[apid_pkg::DutyW-1:0];
    res.average = avg[apid_pkg::SampleW-1:0];
    return 1'b1;
  endfunction

  // full-range register value with extremes and small gains favored
  function automatic logic [apid_pkg::DataW-1:0] draw_reg_value();
    logic [apid_pkg::DataW-1:0] v;
    logic [15:0]                mag;
    v = $urandom;
    mag = 16'($urandom_range(0, 1024));
    case ($urandom_range(0, 6))
      0: v[15:0] = 16'h0000;
      1: v[15:0] = 16'hFFFF;
      2: v[15:0] = 16'h8000;
      3: v[15:0] = 16'h7FFF;
      4, 5: v[15:0] = $urandom_range(0, 1) ? mag : -mag;
      default: ;
    endcase
    return v;
  endfunction

  // apb write: setup cycle then access cycle
  task automatic write_reg(input logic [apid_pkg::IdxW-1:0] idx,
                           input logic [apid_pkg::DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      apid_pkg::RegSetpoint: m_setpoint = value[apid_pkg::SampleW-1:0];
      apid_pkg::RegKp:       m_kp       = value[apid_pkg::GainW-1:0];
      apid_pkg::RegKiDt:     m_ki       = value[apid_pkg::GainW-1:0];
      apid_pkg::RegKdOverDt: m_kd       = value[apid_pkg::GainW-1:0];
      apid_pkg::RegPwmMin:   m_pwm_min  = value[apid_pkg::DutyW-1:0];
      apid_pkg::RegPwmMax:   m_pwm_max  = value[apid_pkg::DutyW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one sample transaction with a random lead-in gap
  task automatic send_sample(input logic [apid_pkg::SampleW-1:0] s, input bit typed,
                             input pid_result_t typed_res);
    int          gap;
    pid_result_t res;
    gap = in_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_pid(s, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // block idle: every result in, plus latency for a sample that closes no group
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleTicks) @(posedge clk);
  endtask

  // stimulus
  initial begin : stimulus
    int                           rand_sent;
    int                           n;
    int                           mode;
    logic [apid_pkg::SampleW-1:0] base;
    logic [apid_pkg::SampleW-1:0] s;
    logic [apid_pkg::DataW-1:0]   lim_lo;
    logic [apid_pkg::DataW-1:0]   lim_hi;
    logic [apid_pkg::DataW-1:0]   swap;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    fail_count = 0;
    in_burst   = 1'b0;
    rand_sent  = 0;
    mode       = 0;
    base       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // register defaults and cleared state after reset
    m_setpoint = apid_pkg::SetpointRst;
    m_kp       = apid_pkg::KpRst;
    m_ki       = '0;
    m_kd       = '0;
    m_pwm_min  = '0;
    m_pwm_max  = apid_pkg::PwmMaxRst;
    grp_sum    = 0;
    grp_count  = 0;
    integ_acc  = 0;
    last_err   = 0;

    foreach (DirTable[i]) begin
      if (DirTable[i].kind == StepWrite) begin
        wait_drained();
        write_reg(DirTable[i].idx, DirTable[i].data);
      end else begin
        send_sample(DirTable[i].data[apid_pkg::SampleW-1:0], DirTable[i].typed,
                    DirTable[i].res);
      end
    end

    // random phases: reprogram, then stream shaped sample groups
    while (rand_sent < RandItems) begin
      wait_drained();
      in_burst = ($urandom_range(0, 3) == 0);
      write_reg(apid_pkg::RegSetpoint, draw_reg_value());
      write_reg(apid_pkg::RegKp, draw_reg_value());
      write_reg(apid_pkg::RegKiDt, draw_reg_value());
      write_reg(apid_pkg::RegKdOverDt, draw_reg_value());
      lim_lo = draw_reg_value();
      lim_hi = draw_reg_value();
      // mostly ordered limits, sometimes crossed
      if ($urandom_range(0, 3) != 0 && lim_lo[15:0] > lim_hi[15:0]) begin
        swap   = lim_lo;
        lim_lo = lim_hi;
        lim_hi = swap;
      end
      write_reg(apid_pkg::RegPwmMin, lim_lo);
      write_reg(apid_pkg::RegPwmMax, lim_hi);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? RegUnmappedA : RegUnmappedB, $urandom);

      n = $urandom_range(1, 6) * apid_pkg::Samples;
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, apid_pkg::Samples - 1);
      repeat (n) begin
        if (grp_count == 0) begin
          mode = $urandom_range(0, 7);
          base = apid_pkg::SampleW'($urandom);
        end
        case (mode)
          3: s = base;
          // constant one below setpoint gives an error of exactly one
          4: s = (m_setpoint == '0) ? base : m_setpoint - 1'b1;
          5: s = $urandom_range(0, 1) ? {apid_pkg::SampleW{1'b1}} : '0;
          6, 7: s = base + apid_pkg::SampleW'($urandom_range(0, 6))
                    - apid_pkg::SampleW'(3);
          default: s = apid_pkg::SampleW'($urandom);
        endcase
        send_sample(s, 1'b0, '0);
        rand_sent++;
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleTicks * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // result side: random stall, then compare each transaction
  initial begin : result_check
    int          hold;
    pid_result_t want;
    out_stall <= 1'b0;
    out_burst = 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      hold = out_burst ? 0 : $urandom_range(0, 10);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: duty %0d average %0d", out_duty, out_average);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_duty !== want.duty) begin
          $error("duty mismatch: expected %0d, actual %0d", want.duty, out_duty);
          fail_count++;
        end
        if (out_average !== want.average) begin
          $error("average mismatch: expected %0d, actual %0d", want.average, out_average);
          fail_count++;
        end
      end
    end
  end

  // hang detection: too long without any transaction or apb activity
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule

// File: files.f
design/apid_pkg.sv
design/averaged_pid_controller_core.sv
sim/tb_averaged_pid_controller_core.sv
